// ----- rtl/adlt_pkg.sv -----
package adlt_pkg;

  localparam int unsigned LENGTH_W = 24;
  localparam int unsigned READ_W = 19;
  localparam int unsigned COUNT_W = 34;
  localparam int unsigned CPB_W = 17;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned MAX_LENGTH_DEF = 262144;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned DIV_DVD_W = 36;
  localparam int unsigned DIV_DVS_W = 28;
  localparam int unsigned DIV_RADIX = 4;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_OVERRIDE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TV_SYSTEM = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DAC_RATE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RATE_KNOWN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_VI_TIME = 3'd4;

  localparam logic [1:0] TV_PAL = 2'd1;
  localparam logic [1:0] TV_MPAL = 2'd2;

  localparam logic [25:0] CLK_NTSC = 26'd48681812;
  localparam logic [25:0] CLK_PAL = 26'd49656530;
  localparam logic [25:0] CLK_MPAL = 26'd48628316;
  localparam logic [5:0] FPS_PAL = 6'd50;
  localparam logic [5:0] FPS_OTHER = 6'd60;
  localparam logic [CPB_W-1:0] CPB_DEFAULT = 17'd500;
  localparam logic [READ_W-1:0] READ_MAX = 19'd524284;

  typedef struct packed {
    logic [1:0] kind;
    logic [LENGTH_W-1:0] length;
  } item_t;

  typedef struct packed {
    logic [READ_W-1:0] read_data;
    logic busy_res;
    logic full_res;
    logic interrupt;
    logic ignored_write;
    logic overrun;
  } result_t;

  typedef struct packed {
    logic [15:0] counts_per_byte_override;
    logic [1:0] tv_system;
    logic [13:0] dac_rate;
    logic rate_known;
    logic [23:0] vi_interrupt_time;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_CLEAR,
    OP_IGNORE,
    OP_WRITE,
    OP_READ,
    OP_STATUS
  } op_t;

  typedef struct packed {
    op_t op;
    logic [LENGTH_W-1:0] length;
  } entry_t;

  typedef struct packed {
    logic valid;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DIV_DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/audio_dma_length_timer.sv -----
// Channel  | Signals                              | Direction
// item     | item_valid, item_ready, item         | in:  kind and length
// result   | result_valid, result_ready, result   | out: read data and status flags
// cfg      | cfg_valid, cfg_ready, cfg_index/data | in:  register writes
//
// Ticks, status reads and most writes are issued from the two-entry queue, then executed
// and registered. A write that starts a countdown, or a tick that starts the queued buffer,
// adds the S_MUL and S_LOAD states for the length times counts-per-byte multiply; a length
// read waits in S_RDIV for the radix-16 iterative divider. After reset or a configuration
// write, counts-per-byte is recomputed, through the same divider when no override is set
// and the rate is known, before the next transaction runs. Reset is synchronous; the queue
// keeps taking transactions while the result waits, until both of its entries are full.
module audio_dma_length_timer #(
  parameter int unsigned MAX_LENGTH = adlt_pkg::MAX_LENGTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  adlt_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output adlt_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [adlt_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [adlt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  adlt_pkg::cfg_regs_t cfg;
  adlt_pkg::push_t push;
  adlt_pkg::entry_t head;
  adlt_pkg::div_req_t div_req;
  adlt_pkg::div_rsp_t div_rsp;
  logic q_full;
  logic head_valid;
  logic pop;
  logic cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        adlt_pkg::CFG_OVERRIDE: begin
          cfg.counts_per_byte_override <= cfg_data[15:0];
        end
        adlt_pkg::CFG_TV_SYSTEM: begin
          cfg.tv_system <= cfg_data[1:0];
        end
        adlt_pkg::CFG_DAC_RATE: begin
          cfg.dac_rate <= cfg_data[13:0];
        end
        adlt_pkg::CFG_RATE_KNOWN: begin
          cfg.rate_known <= cfg_data[0];
        end
        adlt_pkg::CFG_VI_TIME: begin
          cfg.vi_interrupt_time <= cfg_data[23:0];
        end
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  adlt_front #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_front (
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .q_full(q_full),
    .push(push)
  );

  adlt_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(q_full),
    .pop(pop),
    .head_valid(head_valid),
    .head(head)
  );

  adlt_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  adlt_back #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .cfg_write(cfg_write),
    .q_valid(head_valid),
    .q_entry(head),
    .q_pop(pop),
    .div_req(div_req),
    .div_rsp(div_rsp),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

endmodule

// ----- rtl/adlt_front.sv -----
module adlt_front #(
  parameter int unsigned MAX_LENGTH = adlt_pkg::MAX_LENGTH_DEF
) (
  input  logic              item_valid,
  output logic              item_ready,
  input  adlt_pkg::item_t   item,
  input  logic              q_full,
  output adlt_pkg::push_t   push
);

  localparam int unsigned CMP_W = adlt_pkg::LENGTH_W + 1;

  adlt_pkg::op_t op;

  always_comb begin
    case (item.kind)
      adlt_pkg::KIND_TICK: begin
        op = adlt_pkg::OP_TICK;
      end
      adlt_pkg::KIND_WRITE: begin
        if (item.length == '0) begin
          op = adlt_pkg::OP_CLEAR;
        end else if ({1'b0, item.length} >= CMP_W'(MAX_LENGTH)) begin
          op = adlt_pkg::OP_IGNORE;
        end else begin
          op = adlt_pkg::OP_WRITE;
        end
      end
      adlt_pkg::KIND_READ: begin
        op = adlt_pkg::OP_READ;
      end
      default: begin
        op = adlt_pkg::OP_STATUS;
      end
    endcase
  end

  assign item_ready = !q_full;
  assign push.valid = item_valid && !q_full;
  assign push.entry.op = op;
  assign push.entry.length = item.length;

endmodule

// ----- rtl/adlt_queue.sv -----
module adlt_queue (
  input  logic              clk,
  input  logic              rst,
  input  adlt_pkg::push_t   push,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output adlt_pkg::entry_t  head
);

  localparam int unsigned DEPTH = adlt_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  adlt_pkg::entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head = entries[rd_ptr];
  assign do_push = push.valid && !full;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.entry;
    end
  end

endmodule

// ----- rtl/adlt_div.sv -----
module adlt_div (
  input  logic                clk,
  input  logic                rst,
  input  adlt_pkg::div_req_t  req,
  output adlt_pkg::div_rsp_t  rsp
);

  localparam int unsigned DVD_W = adlt_pkg::DIV_DVD_W;
  localparam int unsigned DVS_W = adlt_pkg::DIV_DVS_W;
  localparam int unsigned RADIX = adlt_pkg::DIV_RADIX;
  localparam int unsigned ITER = DVD_W / RADIX;
  localparam int unsigned CNT_W = $clog2(ITER + 1);

  logic running;
  logic done;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] dvd_next;
  logic [DVD_W-1:0] quo_next;
  logic [DVS_W-1:0] rem_next;

  always_comb begin
    logic [DVS_W:0] t;
    logic qb;
    dvd_next = dvd;
    quo_next = quo;
    rem_next = rem;
    for (int i = 0; i < RADIX; i++) begin
      t = {rem_next, dvd_next[DVD_W-1]};
      dvd_next = {dvd_next[DVD_W-2:0], 1'b0};
      qb = (t >= {1'b0, dvs});
      if (qb) begin
        t = t - {1'b0, dvs};
      end
      rem_next = t[DVS_W-1:0];
      quo_next = {quo_next[DVD_W-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= !req.start && running && (cnt == CNT_W'(ITER - 1));
      if (req.start) begin
        running <= 1'b1;
        cnt <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ITER - 1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      quo <= '0;
      rem <= '0;
    end else if (running) begin
      dvd <= dvd_next;
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quo;

endmodule

// ----- rtl/adlt_back.sv -----
module adlt_back #(
  parameter int unsigned MAX_LENGTH = adlt_pkg::MAX_LENGTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  adlt_pkg::cfg_regs_t cfg,
  input  logic                cfg_write,
  input  logic                q_valid,
  input  adlt_pkg::entry_t    q_entry,
  output logic                q_pop,
  output adlt_pkg::div_req_t  div_req,
  input  adlt_pkg::div_rsp_t  div_rsp,
  output logic                result_valid,
  input  logic                result_ready,
  output adlt_pkg::result_t   result
);

  localparam int unsigned LEN_W = $clog2(MAX_LENGTH);
  localparam int unsigned CPB_W = adlt_pkg::CPB_W;
  localparam int unsigned COUNT_W = adlt_pkg::COUNT_W;
  localparam int unsigned READ_W = adlt_pkg::READ_W;
  localparam int unsigned PROD_W = LEN_W + CPB_W;
  localparam int unsigned WIDE_W = PROD_W + COUNT_W;
  localparam int unsigned DVD_W = adlt_pkg::DIV_DVD_W;
  localparam int unsigned DVS_W = adlt_pkg::DIV_DVS_W;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_CPB1 = 8'b0000_0010,
    S_CPB2 = 8'b0000_0100,
    S_EXEC = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_LOAD = 8'b0010_0000,
    S_RDIV = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state;
  logic dirty;
  logic [CPB_W-1:0] cpb;
  logic [COUNT_W-1:0] remaining;
  logic [LEN_W-1:0] queued;
  logic busy;
  logic full;
  adlt_pkg::entry_t cur;
  logic [LEN_W-1:0] mul_len;
  logic [PROD_W-1:0] prod;
  logic [READ_W-1:0] rd;
  logic irq;
  logic ign;
  logic ovr;

  logic [25:0] sys_clk;
  logic [5:0] fps;
  logic [DVD_W:0] rounded;
  logic out_free;
  logic start_cpb;
  logic idle_pop;

  always_comb begin
    case (cfg.tv_system)
      adlt_pkg::TV_PAL: begin
        sys_clk = adlt_pkg::CLK_PAL;
        fps = adlt_pkg::FPS_PAL;
      end
      adlt_pkg::TV_MPAL: begin
        sys_clk = adlt_pkg::CLK_MPAL;
        fps = adlt_pkg::FPS_OTHER;
      end
      default: begin
        sys_clk = adlt_pkg::CLK_NTSC;
        fps = adlt_pkg::FPS_OTHER;
      end
    endcase
  end

  assign start_cpb = (state == S_IDLE) && dirty && (cfg.counts_per_byte_override == '0)
                     && cfg.rate_known;
  assign idle_pop = (state == S_IDLE) && !dirty && q_valid;
  assign q_pop = idle_pop;
  assign out_free = !result_valid || result_ready;
  assign rounded = ({1'b0, div_rsp.quotient} + (DVD_W + 1)'(3)) & ~((DVD_W + 1)'(3));

  always_comb begin
    div_req.start = 1'b0;
    div_req.dividend = DVD_W'(sys_clk);
    div_req.divisor = DVS_W'({1'b0, cfg.dac_rate} + 15'd1);
    if (start_cpb) begin
      div_req.start = 1'b1;
    end else if (state == S_CPB1 && div_rsp.done) begin
      div_req.start = 1'b1;
      div_req.dividend = DVD_W'(cfg.vi_interrupt_time) * DVD_W'(fps);
      div_req.divisor = {div_rsp.quotient[DVS_W-3:0], 2'b00};
    end else if (state == S_EXEC && cur.op == adlt_pkg::OP_READ) begin
      div_req.start = 1'b1;
      div_req.dividend = DVD_W'(remaining);
      div_req.divisor = DVS_W'(cpb);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dirty <= 1'b1;
      remaining <= '0;
      queued <= '0;
      busy <= 1'b0;
      full <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (state == S_IDLE && dirty) begin
        dirty <= cfg_write;
      end else if (cfg_write) begin
        dirty <= 1'b1;
      end
      if (state == S_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (dirty) begin
            if (start_cpb) begin
              state <= S_CPB1;
            end
          end else if (q_valid) begin
            state <= S_EXEC;
          end
        end
        S_CPB1: begin
          if (div_rsp.done) begin
            state <= S_CPB2;
          end
        end
        S_CPB2: begin
          if (div_rsp.done) begin
            state <= S_IDLE;
          end
        end
        S_EXEC: begin
          case (cur.op)
            adlt_pkg::OP_TICK: begin
              state <= (remaining == COUNT_W'(1) && queued != '0) ? S_MUL : S_DONE;
              if (remaining != '0) begin
                remaining <= remaining - 1'b1;
                if (remaining == COUNT_W'(1)) begin
                  full <= 1'b0;
                  if (queued != '0) begin
                    queued <= '0;
                  end else begin
                    busy <= 1'b0;
                  end
                end
              end
            end
            adlt_pkg::OP_CLEAR: begin
              state <= S_DONE;
              remaining <= '0;
              queued <= '0;
              busy <= 1'b0;
              full <= 1'b0;
            end
            adlt_pkg::OP_WRITE: begin
              state <= (queued == '0 && remaining == '0) ? S_MUL : S_DONE;
              busy <= 1'b1;
              if (queued == '0 && remaining != '0) begin
                queued <= cur.length[LEN_W-1:0];
                full <= 1'b1;
              end
            end
            adlt_pkg::OP_READ: begin
              state <= S_RDIV;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_MUL: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (WIDE_W'(prod) > WIDE_W'(COUNT_MAX)) begin
            remaining <= COUNT_MAX;
          end else begin
            remaining <= COUNT_W'(prod);
          end
          state <= S_DONE;
        end
        S_RDIV: begin
          if (div_rsp.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && dirty) begin
      if (cfg.counts_per_byte_override != '0) begin
        cpb <= CPB_W'(cfg.counts_per_byte_override);
      end else if (!cfg.rate_known) begin
        cpb <= adlt_pkg::CPB_DEFAULT;
      end
    end
    if (state == S_CPB2 && div_rsp.done) begin
      cpb <= (div_rsp.quotient == '0) ? CPB_W'(1) : div_rsp.quotient[CPB_W-1:0];
    end
    if (idle_pop) begin
      cur <= q_entry;
      rd <= '0;
      irq <= 1'b0;
      ign <= 1'b0;
      ovr <= 1'b0;
    end
    if (state == S_EXEC) begin
      case (cur.op)
        adlt_pkg::OP_TICK: begin
          if (remaining == COUNT_W'(1)) begin
            irq <= 1'b1;
            mul_len <= queued;
          end
        end
        adlt_pkg::OP_IGNORE: begin
          ign <= 1'b1;
        end
        adlt_pkg::OP_WRITE: begin
          ovr <= (queued != '0);
          mul_len <= cur.length[LEN_W-1:0];
        end
        default: begin
          ign <= 1'b0;
        end
      endcase
    end
    if (state == S_MUL) begin
      prod <= mul_len * cpb;
    end
    if (state == S_RDIV && div_rsp.done) begin
      if (rounded > (DVD_W + 1)'(adlt_pkg::READ_MAX)) begin
        rd <= adlt_pkg::READ_MAX;
      end else begin
        rd <= rounded[READ_W-1:0];
      end
    end
    if (state == S_DONE && out_free) begin
      result.read_data <= rd;
      result.busy_res <= busy;
      result.full_res <= full;
      result.interrupt <= irq;
      result.ignored_write <= ign;
      result.overrun <= ovr;
    end
  end

endmodule

// ----- rtl/adlt_checker.sv -----
module adlt_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input adlt_pkg::result_t result
);

  // A transaction reports at most one of interrupt, ignored write and overrun.
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0({result.interrupt, result.ignored_write, result.overrun}))
    else $error("more than one event flag in a result");

  // A queued buffer always implies a running transfer.
  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.full_res |-> result.busy_res)
    else $error("full reported without busy");

  // An overrun leaves busy set, and an expiry always empties the second buffer.
  a_event_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.overrun || result.interrupt)
      |-> (result.busy_res || !result.overrun) && !(result.interrupt && result.full_res))
    else $error("event flags disagree with status");

  // Read data is a multiple of four and is zero in any result that carries an event flag.
  a_read_data: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.read_data[1:0] == 2'b00 &&
      (!(result.interrupt || result.ignored_write || result.overrun) ||
       result.read_data == '0))
    else $error("malformed read data");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

endmodule

bind audio_dma_length_timer adlt_checker u_checker (
  .clk(clk),
  .rst(rst),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result(result)
);

// ----- tb/tb_audio_dma_length_timer.sv -----
module tb_audio_dma_length_timer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CFG_INDEX_W = adlt_pkg::CFG_INDEX_W;
  localparam int unsigned CFG_DATA_W = adlt_pkg::CFG_DATA_W;
  localparam int unsigned COUNT_W = adlt_pkg::COUNT_W;
  localparam int unsigned LENGTH_W = adlt_pkg::LENGTH_W;
  localparam int unsigned READ_W = adlt_pkg::READ_W;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned END_WAIT = 40;
  localparam int unsigned SHOWN_MISMATCHES = 10;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;
  localparam logic [LENGTH_W-1:0] LEN_TOP = 24'hFFFFFF;
  localparam logic [LENGTH_W-1:0] LEN_LARGEST_OK = 24'h03FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  adlt_pkg::item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  adlt_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [15:0] cpb_override_reg = '0;
  logic [1:0] tv_system_reg = '0;
  logic [13:0] dac_rate_reg = '0;
  logic rate_known_reg = 1'b0;
  logic [23:0] vi_time_reg = '0;

  logic [COUNT_W-1:0] timer_count = '0;
  logic [17:0] queued_len = '0;
  logic busy_flag = 1'b0;
  logic full_flag = 1'b0;

  adlt_pkg::result_t status_due[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit quiet = 1'b0;

  audio_dma_length_timer uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic longint unsigned counts_per_byte_now();
    longint unsigned clk_hz;
    longint unsigned fps;
    longint unsigned bytes_rate;
    longint unsigned cpb;
    if (cpb_override_reg != 0) begin
      cpb = 64'(cpb_override_reg);
    end else if (rate_known_reg) begin
      case (tv_system_reg)
        adlt_pkg::TV_PAL: begin
          clk_hz = 64'(adlt_pkg::CLK_PAL);
          fps = 64'(adlt_pkg::FPS_PAL);
        end
        adlt_pkg::TV_MPAL: begin
          clk_hz = 64'(adlt_pkg::CLK_MPAL);
          fps = 64'(adlt_pkg::FPS_OTHER);
        end
        default: begin
          clk_hz = 64'(adlt_pkg::CLK_NTSC);
          fps = 64'(adlt_pkg::FPS_OTHER);
        end
      endcase
      bytes_rate = (clk_hz / (longint'(dac_rate_reg) + 1)) * 4;
      cpb = (bytes_rate != 0) ? (longint'(vi_time_reg) * fps) / bytes_rate : 0;
    end else begin
      cpb = 64'(adlt_pkg::CPB_DEFAULT);
    end
    if (cpb < 1) cpb = 64'd1;
    return cpb;
  endfunction

  function automatic logic [COUNT_W-1:0] load_count(input logic [LENGTH_W-1:0] len);
    longint unsigned prod;
    prod = longint'(len) * counts_per_byte_now();
    return (prod > COUNT_SAT) ? COUNT_SAT : prod[COUNT_W-1:0];
  endfunction

  function automatic adlt_pkg::result_t step_dma_timer(input logic [1:0] kind,
                                                       input logic [LENGTH_W-1:0] len);
    adlt_pkg::result_t r;
    longint unsigned quo;
    r = '0;
    case (kind)
      adlt_pkg::KIND_TICK: begin
        if (timer_count != 0) begin
          timer_count = timer_count - 1;
          if (timer_count == 0) begin
            r.interrupt = 1'b1;
            full_flag = 1'b0;
            if (queued_len != 0) begin
              timer_count = load_count(LENGTH_W'(queued_len));
              queued_len = '0;
            end else begin
              busy_flag = 1'b0;
            end
          end
        end
      end
      adlt_pkg::KIND_WRITE: begin
        if (len == 0) begin
          timer_count = '0;
          queued_len = '0;
          busy_flag = 1'b0;
          full_flag = 1'b0;
        end else if (len >= adlt_pkg::MAX_LENGTH_DEF) begin
          r.ignored_write = 1'b1;
        end else begin
          busy_flag = 1'b1;
          if (queued_len != 0) begin
            r.overrun = 1'b1;
          end else if (timer_count == 0) begin
            timer_count = load_count(len);
          end else begin
            queued_len = len[17:0];
            full_flag = 1'b1;
          end
        end
      end
      adlt_pkg::KIND_READ: begin
        quo = longint'(timer_count) / counts_per_byte_now();
        quo = (quo + 3) & ~64'd3;
        r.read_data = (quo > adlt_pkg::READ_MAX) ? adlt_pkg::READ_MAX : quo[READ_W-1:0];
      end
      default: begin
      end
    endcase
    r.busy_res = busy_flag;
    r.full_res = full_flag;
    return r;
  endfunction

  task automatic issue_access(input logic [1:0] kind, input logic [LENGTH_W-1:0] len);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item.kind <= kind;
    item.length <= len;
    do @(posedge clk); while (!item_ready);
    status_due.push_back(step_dma_timer(kind, len));
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (status_due.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      adlt_pkg::CFG_OVERRIDE: cpb_override_reg = data[15:0];
      adlt_pkg::CFG_TV_SYSTEM: tv_system_reg = data[1:0];
      adlt_pkg::CFG_DAC_RATE: dac_rate_reg = data[13:0];
      adlt_pkg::CFG_RATE_KNOWN: rate_known_reg = data[0];
      adlt_pkg::CFG_VI_TIME: vi_time_reg = data[23:0];
      default: begin
      end
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] ov, input logic [1:0] tv,
                                input logic [13:0] dac, input logic rk,
                                input logic [23:0] vi);
    drain();
    cfg_write(adlt_pkg::CFG_OVERRIDE, CFG_DATA_W'(ov));
    cfg_write(adlt_pkg::CFG_TV_SYSTEM, CFG_DATA_W'(tv));
    cfg_write(adlt_pkg::CFG_DAC_RATE, CFG_DATA_W'(dac));
    cfg_write(adlt_pkg::CFG_RATE_KNOWN, CFG_DATA_W'(rk));
    cfg_write(adlt_pkg::CFG_VI_TIME, CFG_DATA_W'(vi));
  endtask

  task automatic test_reset_state();
    issue_access(adlt_pkg::KIND_STATUS, LEN_TOP);
    issue_access(adlt_pkg::KIND_TICK, '0);
    issue_access(adlt_pkg::KIND_READ, LEN_TOP);
  endtask

  task automatic test_double_buffering();
    apply_settings(16'd1, 2'd0, 14'd0, 1'b0, 24'd0);
    issue_access(adlt_pkg::KIND_WRITE, '0);
    issue_access(adlt_pkg::KIND_WRITE, 24'h040000);
    issue_access(adlt_pkg::KIND_WRITE, LEN_TOP);
    issue_access(adlt_pkg::KIND_WRITE, 24'd3);
    issue_access(adlt_pkg::KIND_WRITE, 24'd2);
    issue_access(adlt_pkg::KIND_WRITE, 24'd5);
    issue_access(adlt_pkg::KIND_READ, '0);
    issue_access(adlt_pkg::KIND_STATUS, '0);
    repeat (3) issue_access(adlt_pkg::KIND_TICK, '0);
    issue_access(adlt_pkg::KIND_READ, '0);
    repeat (3) issue_access(adlt_pkg::KIND_TICK, LEN_TOP);
    issue_access(adlt_pkg::KIND_WRITE, LEN_LARGEST_OK);
    issue_access(adlt_pkg::KIND_WRITE, '0);
  endtask

  task automatic test_count_limits();
    apply_settings(16'd0, 2'd0, 14'h3FFF, 1'b1, 24'hFFFFFF);
    cfg_write(CFG_SPARE_LO, CFG_DATA_W'($urandom()));
    cfg_write(CFG_SPARE_HI, CFG_DATA_W'($urandom()));
    issue_access(adlt_pkg::KIND_WRITE, LEN_LARGEST_OK);
    issue_access(adlt_pkg::KIND_READ, '0);
    apply_settings(16'd1, 2'd3, 14'd0, 1'b0, 24'd0);
    issue_access(adlt_pkg::KIND_READ, '0);
    issue_access(adlt_pkg::KIND_STATUS, '0);
    issue_access(adlt_pkg::KIND_WRITE, '0);
  endtask

  task automatic run_traffic(input int unsigned count, input int unsigned short_len);
    int unsigned sel;
    logic [LENGTH_W-1:0] rl;
    for (int unsigned i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      rl = LENGTH_W'($urandom());
      if (i == count / 2) drain();
      if (sel < 52) issue_access(adlt_pkg::KIND_TICK, rl);
      else if (sel < 66)
        issue_access(adlt_pkg::KIND_WRITE, LENGTH_W'($urandom_range(1, short_len)));
      else if (sel < 76) issue_access(adlt_pkg::KIND_READ, rl);
      else if (sel < 84) issue_access(adlt_pkg::KIND_STATUS, rl);
      else if (sel < 88) issue_access(adlt_pkg::KIND_WRITE, '0);
      else if (sel < 94) issue_access(adlt_pkg::KIND_WRITE, rl);
      else if (sel < 97)
        issue_access(adlt_pkg::KIND_WRITE, LENGTH_W'($urandom_range(1, LEN_LARGEST_OK)));
      else issue_access(2'($urandom()), rl);
    end
  endtask

  task automatic test_random_traffic();
    apply_settings(16'd1, 2'($urandom()), 14'($urandom()), 1'($urandom()), 24'($urandom()));
    run_traffic(150, 10);
    apply_settings(16'd2, 2'($urandom()), 14'($urandom()), 1'($urandom()), 24'($urandom()));
    run_traffic(130, 6);
    apply_settings(16'hFFFF, 2'd3, 14'h3FFF, 1'b1, 24'hFFFFFF);
    run_traffic(100, 8);
    apply_settings(16'd0, 2'($urandom()), 14'($urandom()), 1'b0, 24'($urandom()));
    run_traffic(100, 8);
    apply_settings(16'd0, 2'($urandom()), 14'($urandom()), 1'b1, 24'd0);
    run_traffic(130, 10);
    apply_settings(16'd0, 2'd3, 14'h3FFF, 1'b1, 24'($urandom_range(0, 1000)));
    run_traffic(130, 4);
    apply_settings(16'd0, adlt_pkg::TV_PAL, 14'd0, 1'b1, 24'hFFFFFF);
    run_traffic(130, 6);
    apply_settings(16'd0, adlt_pkg::TV_MPAL, 14'($urandom()), 1'b1, 24'($urandom()));
    run_traffic(100, 2);
  endtask

  task automatic test_steady_stream();
    apply_settings(16'd3, 2'($urandom()), 14'($urandom()), 1'b1, 24'($urandom()));
    quiet = 1'b1;
    run_traffic(130, 6);
  endtask

  initial begin
    @(negedge rst);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    adlt_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (status_due.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < SHOWN_MISMATCHES)
          $display("unexpected transaction: rd=%0d busy=%b full=%b irq=%b ign=%b ovr=%b",
                   result.read_data, result.busy_res, result.full_res, result.interrupt,
                   result.ignored_write, result.overrun);
      end else begin
        want = status_due.pop_front();
        if (result.read_data !== want.read_data || result.busy_res !== want.busy_res ||
            result.full_res !== want.full_res || result.interrupt !== want.interrupt ||
            result.ignored_write !== want.ignored_write || result.overrun !== want.overrun) begin
          mismatches <= mismatches + 1;
          if (mismatches < SHOWN_MISMATCHES)
            $display({"mismatch: expected rd=%0d busy=%b full=%b irq=%b ign=%b ovr=%b, ",
                      "got rd=%0d busy=%b full=%b irq=%b ign=%b ovr=%b"},
                     want.read_data, want.busy_res, want.full_res, want.interrupt,
                     want.ignored_write, want.overrun,
                     result.read_data, result.busy_res, result.full_res, result.interrupt,
                     result.ignored_write, result.overrun);
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_double_buffering();
    test_count_limits();
    test_random_traffic();
    test_steady_stream();
    drain();
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- audio_dma_length_timer.f -----
rtl/adlt_pkg.sv
rtl/adlt_front.sv
rtl/adlt_queue.sv
rtl/adlt_div.sv
rtl/adlt_back.sv
rtl/audio_dma_length_timer.sv
rtl/adlt_checker.sv
tb/tb_audio_dma_length_timer.sv
